/* rtl/accel_tilt_angles_macros.svh */
// assertion macros for the accelerometer tilt angle block
// expects clk and rst_n in the scope where a macro is used
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// same-cycle implication
`define ATA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ata_pkg.sv */
// shared types, constants and helper functions for the tilt angle cordic pipeline
// no dependencies
package ata_pkg;

  localparam int AXIS_W    = 16;
  localparam int ROLL_W    = 16;
  localparam int PITCH_W   = 15;
  localparam int GUARD     = 14;
  localparam int XW        = 34;
  localparam int ACC_W     = 27;
  localparam int MAG_W     = 31;
  localparam int GAIN_W    = 30;
  localparam int TABLE_LEN = 24;
  localparam int DEF_STEPS = 16;
  localparam int ATAN_W    = 22;

  localparam int ROLL_LIMIT  = 23040;
  localparam int PITCH_LIMIT = 11520;

  localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180 * 65536);

  // atan(2^-i) in degrees times 65536
  localparam logic [ATAN_W-1:0] ATAN_DEG16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic               zero;
    logic [AXIS_W-1:0]  val;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
    side_t                   side;
  } cordic_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // inverse cordic gain in q30, evaluated at elaboration
  function automatic logic [GAIN_W-1:0] inv_gain_q30(input int n);
    logic [63:0] ksq;
    logic [63:0] k;
    logic [63:0] rem;
    logic [63:0] quo;
    ksq = 64'd1 << 60;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i < n) ksq = ksq + (ksq >> (2 * i));
    end
    k = isqrt64(ksq);
    if (k == 0) k = 64'd1;
    // long division of 2^60 by k
    rem = '0;
    quo = '0;
    for (int b = 60; b >= 0; b--) begin
      rem = {rem[62:0], (b == 60)};
      if (rem >= k) begin
        rem = rem - k;
        quo[b] = 1'b1;
      end
    end
    return quo[GAIN_W-1:0];
  endfunction

  // round half up to 1/128 degree and saturate to +-lim
  function automatic logic signed [ROLL_W-1:0] to_angle(
    input logic signed [ACC_W-1:0] acc,
    input int                      lim
  );
    logic signed [ACC_W:0]   s;
    logic signed [ACC_W-9:0] q;
    logic signed [ACC_W-9:0] lim_s;
    s     = {acc[ACC_W-1], acc} + (ACC_W+1)'(256);
    q     = s[ACC_W:9];
    lim_s = (ACC_W-8)'(lim);
    if (q > lim_s) q = lim_s;
    if (q < -lim_s) q = -lim_s;
    return q[ROLL_W-1:0];
  endfunction

endpackage

/* rtl/ata_in_if.sv */
// input channel of the tilt angle block: one three-axis accelerometer sample per item
// no dependencies
interface ata_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

/* rtl/ata_out_if.sv */
// result channel of the tilt angle block: roll and pitch in 1/128 degree
// no dependencies
interface ata_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

/* rtl/ata_pre_stage.sv */
// entry stage: scales the y and z axes and applies the half turn pre-rotation for negative z
// depends on ata_pkg
module ata_pre_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         accel_x,
  input  logic signed [15:0]         accel_y,
  input  logic signed [15:0]         accel_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ata_pkg::cordic_t           out_data
);
  import ata_pkg::*;

  logic    valid_r, valid_nxt;
  cordic_t data_r, data_nxt;
  logic signed [XW-1:0] x0, y0;

  assign x0 = {{(XW-AXIS_W-GUARD){accel_z[AXIS_W-1]}}, accel_z, GUARD'(0)};
  assign y0 = {{(XW-AXIS_W-GUARD){accel_y[AXIS_W-1]}}, accel_y, GUARD'(0)};

  always_comb begin
    data_nxt.side.zero = (accel_y == '0) && (accel_z == '0);
    data_nxt.side.val  = accel_x;
    if (accel_z[AXIS_W-1]) begin
      data_nxt.x   = -x0;
      data_nxt.y   = -y0;
      data_nxt.acc = accel_y[AXIS_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      data_nxt.x   = x0;
      data_nxt.y   = y0;
      data_nxt.acc = '0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

/* rtl/ata_cordic_cell.sv */
// one vectoring micro-rotation with a fixed shift, registered, handing on to the next cell
// depends on ata_pkg
module ata_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ata_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ata_pkg::cordic_t out_data
);
  import ata_pkg::*;

  logic    valid_r, valid_nxt;
  cordic_t data_r, data_nxt;
  logic signed [XW-1:0]    xs, ys;
  logic signed [ACC_W-1:0] step;

  assign xs   = in_data.x >>> SHIFT;
  assign ys   = in_data.y >>> SHIFT;
  assign step = ACC_W'(ATAN_DEG16[SHIFT]);

  always_comb begin
    data_nxt = in_data;
    // a zero residual rotates as if positive
    if (!in_data.y[XW-1]) begin
      data_nxt.x   = in_data.x + ys;
      data_nxt.y   = in_data.y - xs;
      data_nxt.acc = in_data.acc + step;
    end else begin
      data_nxt.x   = in_data.x - ys;
      data_nxt.y   = in_data.y + xs;
      data_nxt.acc = in_data.acc - step;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

/* rtl/ata_gain_stage.sv */
// between the chains: forms roll, scales the roll magnitude by the inverse gain,
// and sets up the pitch vector; depends on ata_pkg
module ata_gain_stage #(
  parameter int STEPS = ata_pkg::DEF_STEPS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ata_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ata_pkg::cordic_t out_data
);
  import ata_pkg::*;

  localparam logic [GAIN_W-1:0] INVK = inv_gain_q30(STEPS);

  logic                        valid_r, valid_nxt;
  logic [MAG_W+GAIN_W-1:0]     prod_r, prod_nxt;
  logic signed [AXIS_W-1:0]    ax_r;
  logic signed [ROLL_W-1:0]    roll_r, roll_nxt;
  logic [MAG_W-1:0]            mag;
  logic [MAG_W-1:0]            r;
  logic signed [XW-1:0]        ax_ext;

  always_comb begin
    roll_nxt = in_data.side.zero ? '0 : to_angle(in_data.acc, ROLL_LIMIT);
    if (!in_data.side.zero && !in_data.x[XW-1] && (in_data.x != '0))
      mag = in_data.x[MAG_W-1:0];
    else
      mag = '0;
    prod_nxt = {{GAIN_W{1'b0}}, mag} * {{MAG_W{1'b0}}, INVK};
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r <= prod_nxt;
      ax_r   <= in_data.side.val;
      roll_r <= roll_nxt;
    end
  end

  assign r      = prod_r[MAG_W+GAIN_W-1:GAIN_W];
  assign ax_ext = {{(XW-AXIS_W-GUARD){ax_r[AXIS_W-1]}}, ax_r, GUARD'(0)};

  always_comb begin
    out_data.x         = {{(XW-MAG_W){1'b0}}, r};
    out_data.y         = -ax_ext;
    out_data.acc       = '0;
    // pitch of a null vector stays zero
    out_data.side.zero = (r == '0) && (ax_r == '0);
    out_data.side.val  = roll_r;
  end

  assign out_valid = valid_r;
endmodule

/* rtl/ata_out_stage.sv */
// result register: forms pitch and holds the finished item for the receiver
// depends on ata_pkg and ata_out_if
module ata_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ata_pkg::cordic_t in_data,
  ata_out_if.source        out_ch
);
  import ata_pkg::*;

  logic                      valid_r, valid_nxt;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic signed [ROLL_W-1:0]  pitch_full;

  assign pitch_full = to_angle(in_data.acc, PITCH_LIMIT);
  assign pitch_nxt  = in_data.side.zero ? '0 : pitch_full[PITCH_W-1:0];

  assign in_ready  = !valid_r || out_ch.ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      roll_r  <= in_data.side.val;
      pitch_r <= pitch_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
endmodule

/* rtl/accel_tilt_angles.sv */
// Accelerometer tilt angles: roll = atan2(y, z), pitch = atan2(-x, sqrt(y^2 + z^2)).
// Input channel in_ch carries one sample (accel_x, accel_y, accel_z, signed raw counts);
// result channel out_ch carries roll_angle and pitch_angle in 1/128 degree, one per item.
// Both use valid/ready; an item moves on a clock edge with valid and ready high.
// The datapath is two chains of CORDIC_STEPS vectoring cells: an entry stage, the roll
// chain, a gain stage (roll rounding and one 31x30 multiply by the inverse gain), the
// pitch chain and a result register. A new sample is taken every cycle and throughput is
// one item per clock while out_ch is not stalled.
// Every stage has its own valid bit and takes a new item when it is empty or its
// neighbor takes its item, so bubbles close up while out_ch is stalled and in_ch.ready
// falls only once every stage holds an item. A stalled result stays in the result
// register unchanged. rst_n (synchronous, active low) empties the pipeline; there
// is no other state and no settling time after reset.
// depends on ata_pkg, ata_in_if, ata_out_if, the stage modules and the macros header
`include "accel_tilt_angles_macros.svh"

module accel_tilt_angles #(
  parameter int CORDIC_STEPS = ata_pkg::DEF_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  ata_in_if.sink    in_ch,
  ata_out_if.source out_ch
);
  import ata_pkg::*;

  logic    roll_v   [0:CORDIC_STEPS];
  logic    roll_rdy [0:CORDIC_STEPS];
  cordic_t roll_d   [0:CORDIC_STEPS];
  logic    pitch_v   [0:CORDIC_STEPS];
  logic    pitch_rdy [0:CORDIC_STEPS];
  cordic_t pitch_d   [0:CORDIC_STEPS];

  ata_pre_stage u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .accel_x   (in_ch.accel_x),
    .accel_y   (in_ch.accel_y),
    .accel_z   (in_ch.accel_z),
    .out_valid (roll_v[0]),
    .out_ready (roll_rdy[0]),
    .out_data  (roll_d[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_roll
    ata_cordic_cell #(.SHIFT(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (roll_v[k]),
      .in_ready  (roll_rdy[k]),
      .in_data   (roll_d[k]),
      .out_valid (roll_v[k+1]),
      .out_ready (roll_rdy[k+1]),
      .out_data  (roll_d[k+1])
    );
  end

  ata_gain_stage #(.STEPS(CORDIC_STEPS)) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (roll_v[CORDIC_STEPS]),
    .in_ready  (roll_rdy[CORDIC_STEPS]),
    .in_data   (roll_d[CORDIC_STEPS]),
    .out_valid (pitch_v[0]),
    .out_ready (pitch_rdy[0]),
    .out_data  (pitch_d[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
    ata_cordic_cell #(.SHIFT(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (pitch_v[k]),
      .in_ready  (pitch_rdy[k]),
      .in_data   (pitch_d[k]),
      .out_valid (pitch_v[k+1]),
      .out_ready (pitch_rdy[k+1]),
      .out_data  (pitch_d[k+1])
    );
  end

  ata_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (pitch_v[CORDIC_STEPS]),
    .in_ready (pitch_rdy[CORDIC_STEPS]),
    .in_data  (pitch_d[CORDIC_STEPS]),
    .out_ch   (out_ch)
  );

  `ATA_ASSERT_NOW(a_full_on_backpressure, !in_ch.ready,
    out_ch.valid && !out_ch.ready, "input stalled while result side is free")
  `ATA_ASSERT_NEXT(a_entry_loaded, in_ch.valid && in_ch.ready,
    roll_v[0], "accepted item did not reach the entry stage")
  `ATA_ASSERT_NOW(a_roll_range, out_ch.valid,
    (out_ch.roll_angle <= 16'sd23040) && (out_ch.roll_angle >= -16'sd23040),
    "roll outside +-180 degrees")
  `ATA_ASSERT_NOW(a_pitch_range, out_ch.valid,
    (out_ch.pitch_angle <= 15'sd11520) && (out_ch.pitch_angle >= -15'sd11520),
    "pitch outside +-90 degrees")

endmodule
